[design/bdq_pkg.sv]
`timescale 1ns / 1ps
// Shared package for the bounded deque with indexed read.
// Holds operation and status codes and the response struct; no dependencies.
package bdq_pkg;

    // Operation codes carried on the operation field.
    localparam logic [2:0] OP_PUSH_TAIL  = 3'd0;
    localparam logic [2:0] OP_PUSH_FRONT = 3'd1;
    localparam logic [2:0] OP_POP_BACK   = 3'd2;
    localparam logic [2:0] OP_READ_INDEX = 3'd3;
    localparam logic [2:0] OP_READ_FRONT = 3'd4;
    localparam logic [2:0] OP_READ_BACK  = 3'd5;

    // Status codes returned with every result word.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // Width of the external data ports.
    localparam int PORT_WIDTH = 32;

    // Decision made by the pointer unit for one accepted word.
    typedef struct packed {
        logic       mem_we;
        logic       mem_re;
        logic [1:0] status;
        logic       now_empty;
    } t_resp;

endpackage

[design/bdq_ram.sv]
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module bdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Storage array and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[design/bdq_ptr.sv]
`timescale 1ns / 1ps
// Head pointer and entry count of the ring, plus the address and status decode.
// Depends on bdq_pkg.
module bdq_ptr #(
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_accept,
    input  logic [2:0]               i_operation,
    input  logic [9:0]               i_index,
    output logic [$clog2(DEPTH)-1:0] o_mem_addr,
    output bdq_pkg::t_resp           o_resp
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = (CW > 10) ? CW : 10;
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);
    localparam logic [CW-1:0] LAST_OFFS  = CW'(DEPTH - 1);
    localparam logic [CW:0]   WRAP       = (CW + 1)'(DEPTH);

    logic [AW-1:0] r_head;
    logic [CW-1:0] r_count;
    logic [AW-1:0] n_head;
    logic [CW-1:0] n_count;

    logic          full;
    logic          empty;
    logic [IW-1:0] idx_w;
    logic          idx_bad;
    logic [CW-1:0] offset;
    logic [CW:0]   sum;
    logic [CW:0]   wrapped;
    logic [AW-1:0] pos;
    bdq_pkg::t_resp resp;

    assign full    = (r_count == FULL_COUNT);
    assign empty   = (r_count == '0);
    assign idx_w   = IW'(i_index);
    assign idx_bad = (idx_w >= IW'(r_count));

    // Offset from the head that the operation addresses.
    always_comb begin
        case (i_operation)
            bdq_pkg::OP_PUSH_TAIL:  offset = r_count;
            bdq_pkg::OP_PUSH_FRONT: offset = LAST_OFFS;
            bdq_pkg::OP_POP_BACK:   offset = r_count - CW'(1);
            bdq_pkg::OP_READ_INDEX: offset = idx_w[CW-1:0];
            bdq_pkg::OP_READ_BACK:  offset = r_count - CW'(1);
            default:                offset = '0;
        endcase
    end

    // Ring position: the sum stays below twice the depth, so one subtract wraps it.
    assign sum     = (CW + 1)'(r_head) + (CW + 1)'(offset);
    assign wrapped = (sum >= WRAP) ? (sum - WRAP) : sum;
    assign pos     = wrapped[AW-1:0];

    // Status, memory access and next pointer state.
    always_comb begin
        resp.mem_we = 1'b0;
        resp.mem_re = 1'b0;
        resp.status = bdq_pkg::ST_OK;
        n_head      = r_head;
        n_count     = r_count;
        case (i_operation)
            bdq_pkg::OP_PUSH_TAIL: begin
                if (full) begin
                    resp.status = bdq_pkg::ST_FULL;
                end else begin
                    resp.mem_we = 1'b1;
                    n_count     = r_count + CW'(1);
                end
            end
            bdq_pkg::OP_PUSH_FRONT: begin
                if (full) begin
                    resp.status = bdq_pkg::ST_FULL;
                end else begin
                    resp.mem_we = 1'b1;
                    n_head      = pos;
                    n_count     = r_count + CW'(1);
                end
            end
            bdq_pkg::OP_POP_BACK: begin
                if (empty) begin
                    resp.status = bdq_pkg::ST_EMPTY;
                end else begin
                    resp.mem_re = 1'b1;
                    n_count     = r_count - CW'(1);
                end
            end
            bdq_pkg::OP_READ_INDEX: begin
                if (idx_bad) begin
                    resp.status = bdq_pkg::ST_EMPTY;
                end else begin
                    resp.mem_re = 1'b1;
                end
            end
            bdq_pkg::OP_READ_FRONT, bdq_pkg::OP_READ_BACK: begin
                if (empty) begin
                    resp.status = bdq_pkg::ST_EMPTY;
                end else begin
                    resp.mem_re = 1'b1;
                end
            end
            default: begin
                resp.status = bdq_pkg::ST_OK;
            end
        endcase
        resp.now_empty = (n_count == '0);
    end

    // Pointer registers update only on an accepted word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else if (i_accept) begin
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    assign o_mem_addr = pos;
    assign o_resp     = resp;

endmodule

[design/bounded_deque_with_indexed_read_core.sv]
`timescale 1ns / 1ps
// Bounded deque with indexed read: o_strobe is high in the cycle after each accepted start.
// Throughput is one word per cycle while busy is low; each word makes a single memory
// access with a registered read, and the pointers update at accept.
// Reset is synchronous, active low; busy is set by reset and cleared once it is released.
// Contents are not cleared; the receiver cannot stall, so results are never held.
module bounded_deque_with_indexed_read_core #(
    parameter int DEPTH      = 1024,
    parameter int DATA_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_operation,
    input  logic [31:0] i_value,
    input  logic [9:0]  i_index,
    output logic        o_strobe,
    output logic [31:0] o_data,
    output logic [1:0]  o_status,
    output logic        o_empty
);

    localparam int AW = $clog2(DEPTH);
    localparam int PW = bdq_pkg::PORT_WIDTH;
    localparam int XW = (DATA_WIDTH > PW) ? DATA_WIDTH : PW;

    logic                  accept;
    logic [AW-1:0]         mem_addr;
    bdq_pkg::t_resp        resp;
    logic [XW-1:0]         value_ext;
    logic [DATA_WIDTH-1:0] rdata;
    logic [XW-1:0]         rdata_ext;

    logic       r_busy;
    logic       r_strobe;
    logic       r_rd;
    logic [1:0] r_status;
    logic       r_empty;

    assign accept    = start && !r_busy;
    assign value_ext = XW'(i_value);

    // Pointer and decode unit.
    bdq_ptr #(
        .DEPTH(DEPTH)
    ) u_ptr (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_operation(i_operation),
        .i_index    (i_index),
        .o_mem_addr (mem_addr),
        .o_resp     (resp)
    );

    // Entry store.
    bdq_ram #(
        .WIDTH(DATA_WIDTH),
        .DEPTH(DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (accept && resp.mem_we),
        .i_waddr(mem_addr),
        .i_wdata(value_ext[DATA_WIDTH-1:0]),
        .i_re   (accept && resp.mem_re),
        .i_raddr(mem_addr),
        .o_rdata(rdata)
    );

    // Result word registers, aligned with the memory read.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b1;
            r_strobe <= 1'b0;
            r_rd     <= 1'b0;
            r_status <= bdq_pkg::ST_OK;
            r_empty  <= 1'b1;
        end else begin
            r_busy   <= 1'b0;
            r_strobe <= accept;
            if (accept) begin
                r_rd     <= resp.mem_re;
                r_status <= resp.status;
                r_empty  <= resp.now_empty;
            end
        end
    end

    assign rdata_ext = XW'(rdata);
    assign busy      = r_busy;
    assign o_strobe  = r_strobe;
    assign o_data    = r_rd ? rdata_ext[PW-1:0] : '0;
    assign o_status  = r_status;
    assign o_empty   = r_empty;

    // A result word appears in the cycle after each accepted word.
    a_strobe_follows_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_strobe)
        else $error("result word missing after accept");

    a_no_spurious_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !accept |=> !o_strobe)
        else $error("result word without accept");

    // A failed operation never returns data.
    a_zero_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status != bdq_pkg::ST_OK) |-> (o_data == '0))
        else $error("nonzero data with error status");

    // A rejected push means the deque was full, so it cannot be empty.
    a_full_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status == bdq_pkg::ST_FULL) |-> !o_empty)
        else $error("full status with empty flag");

endmodule
